[hw/rtl/blcg_pkg.sv]
// Shared widths, constants and control types of the bounded LCG random block.
`timescale 1ns / 1ps

package blcg_pkg;

	// Generator state and field width.
	localparam int STATE_W = 15;
	typedef logic [STATE_W-1:0] state_t;

	// Largest value of the generator, also the dividend of the range division.
	localparam state_t MAX_VALUE = 15'd32767;

	// LCG constants reduced modulo 2^15; only their low bits reach the state.
	localparam state_t LCG_MUL = 15'(214013 % 32768);
	localparam state_t LCG_ADD = 15'(2531011 % 32768);

	// Step counter of the bit-serial divider.
	localparam int CNT_W = $clog2(STATE_W);
	typedef logic [CNT_W-1:0] cnt_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the limit, start limit division
		logic take_div;  // keep the range divisor
		logic step;      // advance the generator, start draw division
		logic emit;      // load the result register
	} blcg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;  // divider finished this cycle
		logic q_ok;      // quotient is within the limit
		logic out_free;  // result register can take a new result
	} blcg_sts_t;

endpackage

[hw/rtl/blcg_if.sv]
// Valid/ready channel interfaces for the request and the result.
`timescale 1ns / 1ps

interface blcg_req_if;
	import blcg_pkg::*;

	logic   valid;
	logic   ready;
	state_t limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface

interface blcg_rsp_if;
	import blcg_pkg::*;

	logic   valid;
	logic   ready;
	state_t value;
	state_t raw_state;

	modport source (output valid, output value, output raw_state, input ready);
	modport sink (input valid, input value, input raw_state, output ready);
endinterface

[hw/rtl/blcg_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module blcg_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  blcg_pkg::state_t dividend,
	input  blcg_pkg::state_t divisor,
	output blcg_pkg::state_t quotient,
	output logic            done
);
	import blcg_pkg::*;

	localparam cnt_t LAST = CNT_W'(STATE_W - 1);

	state_t          rem_q;
	state_t          dvd_q;
	state_t          dsr_q;
	cnt_t            cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [STATE_W:0] trial;
	logic            fits;

	// Shift the next dividend bit into the partial remainder and compare.
	always_comb begin
		trial = {rem_q, dvd_q[STATE_W-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	// Control of the division run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and quotient registers; quotient bits replace dividend bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? STATE_W'(trial - {1'b0, dsr_q}) : trial[STATE_W-1:0];
			dvd_q <= {dvd_q[STATE_W-2:0], fits};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;
endmodule

[hw/rtl/blcg_dp.sv]
// Datapath: generator state, limit and divisor registers, divider and result register.
`timescale 1ns / 1ps

module blcg_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  blcg_pkg::blcg_cmd_t cmd,
	output blcg_pkg::blcg_sts_t sts,
	input  blcg_pkg::state_t    limit,
	input  logic                seed_we,
	input  blcg_pkg::state_t    seed_wdata,
	output logic                out_valid,
	input  logic                out_ready,
	output blcg_pkg::state_t    out_value,
	output blcg_pkg::state_t    out_raw_state
);
	import blcg_pkg::*;

	state_t          state_q;
	state_t          lim_q;
	state_t          div_q;
	state_t          value_q;
	state_t          raw_q;
	logic            out_valid_q;
	state_t          lim_sat;
	logic [2*STATE_W-1:0] prod;
	state_t          next_state;
	logic            div_start;
	state_t          div_dividend;
	state_t          div_divisor;
	state_t          quotient;
	logic            div_done;

	// Saturate the limit so the range divisor never becomes zero.
	assign lim_sat = (limit >= MAX_VALUE) ? MAX_VALUE - 1'b1 : limit;

	// Next generator state modulo 2^15.
	always_comb begin
		prod       = (2*STATE_W)'(state_q) * (2*STATE_W)'(LCG_MUL);
		next_state = prod[STATE_W-1:0] + LCG_ADD;
	end

	// The divider first forms the range divisor, then divides each draw.
	assign div_start    = cmd.load || cmd.step;
	assign div_dividend = cmd.load ? MAX_VALUE : next_state;
	assign div_divisor  = cmd.load ? STATE_W'(lim_sat + 1'b1) : div_q;

	blcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// Generator state: reset and seed writes load it, each draw advances it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (seed_we) begin
			state_q <= seed_wdata;
		end else if (cmd.step) begin
			state_q <= next_state;
		end
	end

	// Limit and range divisor of the item in progress.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lim_q <= lim_sat;
		end
		if (cmd.take_div) begin
			div_q <= quotient;
		end
	end

	// Result register that parts the request side from the result side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= quotient;
			raw_q   <= state_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.q_ok     = (quotient <= lim_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_value     = value_q;
	assign out_raw_state = raw_q;
endmodule

[hw/rtl/blcg_ctrl.sv]
// Controller: sequences limit division, draws, rejection and result transfer.
`timescale 1ns / 1ps

module blcg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  blcg_pkg::blcg_sts_t sts,
	output blcg_pkg::blcg_cmd_t cmd
);
	import blcg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LDIV = 3'd1;
	localparam logic [2:0] S_STEP = 3'd2;
	localparam logic [2:0] S_QDIV = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LDIV;
				end
			end
			S_LDIV: begin
				if (sts.div_done) begin
					cmd.take_div = 1'b1;
					state_d      = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_QDIV;
			end
			S_QDIV: begin
				if (sts.div_done) begin
					state_d = sts.q_ok ? S_OUT : S_STEP;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[hw/rtl/bounded_lcg_random_rejection.sv]
// Bounded LCG random number block with rejection sampling; top level.
// After a request is taken, the limit division forms the range divisor; each draw then
// advances the generator and divides the new state by it in the bit-serial divider,
// and a draw whose quotient exceeds the limit is rejected and drawn again.
// One item is in progress at a time; a new request is taken while a result waits.
// Reset clears the generator state; a seed write reloads it.
`timescale 1ns / 1ps

module bounded_lcg_random_rejection (
	input  logic             clk,
	input  logic             arst_n,
	blcg_req_if.sink         req,
	blcg_rsp_if.source       rsp,
	input  logic             seed_we,
	input  blcg_pkg::state_t seed_wdata
);
	import blcg_pkg::*;

	blcg_cmd_t cmd;
	blcg_sts_t sts;

	// Sequencing.
	blcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and storage.
	blcg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.limit         (req.limit),
		.seed_we       (seed_we),
		.seed_wdata    (seed_wdata),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_value     (rsp.value),
		.out_raw_state (rsp.raw_state)
	);
endmodule
